@@ rtl/dsrs_pkg.sv @@
// Shared types, constants and phase tables for the dual stepper ramp sequencer.
package dsrs_pkg;

	localparam int StepBits      = 12;
	localparam int RateBits      = 16;
	localparam int IntervalBits  = 20;
	localparam int TicksPerSecond = 1000000;
	localparam int ProdBits      = StepBits + RateBits;
	localparam int DivCntBits    = $clog2(IntervalBits);

	localparam logic [IntervalBits-1:0] TicksConst = IntervalBits'(TicksPerSecond);

	localparam logic [1:0] RampNone  = 2'd0;
	localparam logic [1:0] RampZoom  = 2'd1;
	localparam logic [1:0] RampFocus = 2'd2;

	localparam logic [1:0] StatIdle     = 2'd0;
	localparam logic [1:0] StatAccepted = 2'd1;
	localparam logic [1:0] StatRejected = 2'd2;
	localparam logic [1:0] StatRunning  = 2'd3;

	localparam logic [1:0] RegEightPhase = 2'd0;
	localparam logic [1:0] RegSpeedMin   = 2'd1;
	localparam logic [1:0] RegSpeedMax   = 2'd2;
	localparam logic [1:0] RegSpeedInc   = 2'd3;

	localparam logic ActStart = 1'b0;

	typedef struct packed {
		logic       latch;
		logic       setup;
		logic       div_min;
		logic       mul;
		logic       div_ramp;
		logic       set_interval;
		logic       step;
		logic       decrement;
		logic       stop;
		logic       emit;
		logic [1:0] status;
		logic       done;
	} dp_cmd_t;

	typedef struct packed {
		logic is_start;
		logic running;
		logic interval_gt1;
		logic steps_left;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	function automatic logic [3:0] table_four(input logic [1:0] p);
		case (p)
			2'd0: table_four = 4'h9;
			2'd1: table_four = 4'h5;
			2'd2: table_four = 4'h6;
			default: table_four = 4'hA;
		endcase
	endfunction

	function automatic logic [3:0] table_eight(input logic [2:0] p);
		case (p)
			3'd0: table_eight = 4'h1;
			3'd1: table_eight = 4'h5;
			3'd2: table_eight = 4'h4;
			3'd3: table_eight = 4'h6;
			3'd4: table_eight = 4'h2;
			3'd5: table_eight = 4'hA;
			3'd6: table_eight = 4'h8;
			default: table_eight = 4'h9;
		endcase
	endfunction

endpackage

@@ rtl/dsrs_div.sv @@
// Restoring serial divider: tick rate divided by a 16-bit speed, one bit per cycle.
module dsrs_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 go,
	input  logic [dsrs_pkg::RateBits-1:0]        divisor,
	output logic                                 done,
	output logic [dsrs_pkg::IntervalBits-1:0]    quotient
);

	logic                                busy_q;
	logic                                done_q;
	logic [dsrs_pkg::DivCntBits-1:0]     cnt_q;
	logic [dsrs_pkg::RateBits-1:0]       rem_q;
	logic [dsrs_pkg::RateBits-1:0]       d_q;
	logic [dsrs_pkg::IntervalBits-1:0]   quo_q;
	logic [dsrs_pkg::RateBits:0]         rem_sh;
	logic [dsrs_pkg::RateBits:0]         diff;
	logic                                fits;

	assign rem_sh = {rem_q, quo_q[dsrs_pkg::IntervalBits-1]};
	assign diff   = rem_sh - {1'b0, d_q};
	assign fits   = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == dsrs_pkg::DivCntBits'(dsrs_pkg::IntervalBits - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			d_q   <= divisor;
			rem_q <= '0;
			quo_q <= dsrs_pkg::TicksConst;
		end else if (busy_q) begin
			rem_q <= fits ? diff[dsrs_pkg::RateBits-1:0] : rem_sh[dsrs_pkg::RateBits-1:0];
			quo_q <= {quo_q[dsrs_pkg::IntervalBits-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/dsrs_dp.sv @@
// Datapath: motor state, ramp speed, interval divider, config and output registers.
module dsrs_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [dsrs_pkg::RateBits-1:0]      cfg_data,
	input  logic [31:0]                        s_tdata,
	input  logic                               s_tuser,
	input  logic                               m_tready,
	input  dsrs_pkg::dp_cmd_t                  cmd,
	output dsrs_pkg::dp_stat_t                 stat,
	output logic                               m_tvalid,
	output logic [15:0]                        m_tdata
);

	localparam int SB = dsrs_pkg::StepBits;
	localparam int RB = dsrs_pkg::RateBits;
	localparam int IB = dsrs_pkg::IntervalBits;
	localparam int PB = dsrs_pkg::ProdBits;

	// config
	logic          eight_q;
	logic [RB-1:0] spd_min_q, spd_max_q, spd_inc_q;

	// latched item
	logic          action_q;
	logic [SB-1:0] in_zsteps_q, in_fsteps_q;
	logic          in_ztele_q, in_ffar_q;

	// move state
	logic [SB-1:0] zoom_rem_q, focus_rem_q;
	logic          zoom_dir_q, focus_dir_q;
	logic [2:0]    zoom_ph_q, focus_ph_q;
	logic [1:0]    ramp_motor_q;
	logic [SB-1:0] ramp_len_q;
	logic [IB-1:0] interval_q;
	logic          running_q;
	logic [3:0]    zoom_drv_q, focus_drv_q;
	logic [PB-1:0] prod_q;

	// output register
	logic          out_valid_q;
	logic [3:0]    out_zoom_q, out_focus_q;
	logic [1:0]    out_status_q;
	logic          out_done_q;

	logic [SB-1:0] cur, prog;
	logic [PB:0]   spd_sum;
	logic [RB-1:0] spd_ramp, spd_sel, div_d;
	logic          div_go, div_done;
	logic [IB-1:0] quotient;
	logic [2:0]    zoom_ph_nx, focus_ph_nx;
	logic [3:0]    zoom_ent, focus_ent;

	always_comb begin
		cur = (ramp_motor_q == dsrs_pkg::RampZoom) ? zoom_rem_q : focus_rem_q;
		if (cur <= (ramp_len_q >> 1))
			prog = cur;
		else if (cur > ramp_len_q)
			prog = '0;
		else
			prog = ramp_len_q - cur;
	end

	always_comb begin
		spd_sum = {{(PB+1-RB){1'b0}}, spd_min_q} + {1'b0, prod_q};
		if (spd_sum >= {{(PB+1-RB){1'b0}}, spd_max_q})
			spd_ramp = spd_max_q;
		else
			spd_ramp = spd_sum[RB-1:0];
		if (cmd.div_min || ramp_motor_q == dsrs_pkg::RampNone)
			spd_sel = spd_min_q;
		else
			spd_sel = spd_ramp;
		div_d = (spd_sel == '0) ? RB'(1) : spd_sel;
	end

	assign div_go = cmd.div_min | cmd.div_ramp;

	dsrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (quotient)
	);

	function automatic logic [2:0] next_phase(input logic [2:0] p, input logic dir,
	                                          input logic eight);
		logic [2:0] mask;
		mask = eight ? 3'd7 : 3'd3;
		next_phase = dir ? ((p - 3'd1) & mask) : ((p + 3'd1) & mask);
	endfunction

	assign zoom_ph_nx  = next_phase(zoom_ph_q, zoom_dir_q, eight_q);
	assign focus_ph_nx = next_phase(focus_ph_q, focus_dir_q, eight_q);
	assign zoom_ent    = eight_q ? dsrs_pkg::table_eight(zoom_ph_nx)
	                             : dsrs_pkg::table_four(zoom_ph_nx[1:0]);
	assign focus_ent   = eight_q ? dsrs_pkg::table_eight(focus_ph_nx)
	                             : dsrs_pkg::table_four(focus_ph_nx[1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eight_q   <= 1'b0;
			spd_min_q <= RB'(300);
			spd_max_q <= RB'(800);
			spd_inc_q <= RB'(15);
		end else if (cfg_we) begin
			case (cfg_index)
				dsrs_pkg::RegEightPhase: eight_q   <= cfg_data[0];
				dsrs_pkg::RegSpeedMin:   spd_min_q <= cfg_data;
				dsrs_pkg::RegSpeedMax:   spd_max_q <= cfg_data;
				dsrs_pkg::RegSpeedInc:   spd_inc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q    <= s_tuser;
			in_zsteps_q <= s_tdata[SB-1:0];
			in_ztele_q  <= s_tdata[SB];
			in_fsteps_q <= s_tdata[2*SB:SB+1];
			in_ffar_q   <= s_tdata[2*SB+1];
		end
		if (cmd.mul)
			prod_q <= prog * spd_inc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_rem_q   <= '0;
			focus_rem_q  <= '0;
			zoom_dir_q   <= 1'b0;
			focus_dir_q  <= 1'b0;
			zoom_ph_q    <= '0;
			focus_ph_q   <= '0;
			ramp_motor_q <= dsrs_pkg::RampNone;
			ramp_len_q   <= '0;
			interval_q   <= '0;
			running_q    <= 1'b0;
			zoom_drv_q   <= '0;
			focus_drv_q  <= '0;
		end else begin
			if (cmd.setup) begin
				zoom_rem_q  <= in_zsteps_q;
				focus_rem_q <= in_fsteps_q;
				zoom_dir_q  <= in_ztele_q;
				focus_dir_q <= in_ffar_q;
				running_q   <= 1'b1;
				if (in_zsteps_q != '0 && in_fsteps_q == '0) begin
					ramp_motor_q <= dsrs_pkg::RampZoom;
					ramp_len_q   <= in_zsteps_q;
				end else if (in_zsteps_q == '0 && in_fsteps_q != '0) begin
					ramp_motor_q <= dsrs_pkg::RampFocus;
					ramp_len_q   <= in_fsteps_q;
				end else if (in_zsteps_q != '0) begin
					if (in_zsteps_q > in_fsteps_q) begin
						ramp_motor_q <= dsrs_pkg::RampFocus;
						ramp_len_q   <= in_fsteps_q;
					end else begin
						ramp_motor_q <= dsrs_pkg::RampZoom;
						ramp_len_q   <= in_zsteps_q;
					end
				end else begin
					ramp_motor_q <= dsrs_pkg::RampNone;
					ramp_len_q   <= '0;
				end
			end
			if (cmd.set_interval)
				interval_q <= quotient;
			else if (cmd.decrement)
				interval_q <= interval_q - 1'b1;
			if (cmd.step) begin
				if (zoom_rem_q != '0) begin
					zoom_ph_q  <= zoom_ph_nx;
					zoom_drv_q <= {zoom_ent[3], zoom_ent[0], zoom_ent[1], zoom_ent[2]};
					zoom_rem_q <= zoom_rem_q - 1'b1;
				end
				if (focus_rem_q != '0) begin
					focus_ph_q  <= focus_ph_nx;
					focus_drv_q <= focus_ent;
					focus_rem_q <= focus_rem_q - 1'b1;
				end
			end
			if (cmd.stop) begin
				zoom_drv_q  <= '0;
				focus_drv_q <= '0;
				running_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_zoom_q   <= zoom_drv_q;
			out_focus_q  <= focus_drv_q;
			out_status_q <= cmd.status;
			out_done_q   <= cmd.done;
		end
	end

	assign stat.is_start     = (action_q == dsrs_pkg::ActStart);
	assign stat.running      = running_q;
	assign stat.interval_gt1 = interval_q > IB'(1);
	assign stat.steps_left   = (zoom_rem_q != '0) || (focus_rem_q != '0);
	assign stat.div_done     = div_done;
	assign stat.out_free     = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_done_q, out_status_q, out_focus_q, out_zoom_q};

endmodule

@@ rtl/dsrs_ctrl.sv @@
// Controller: sequences one item at a time through decode and, where needed, ramp multiply and divide, then output.
module dsrs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  dsrs_pkg::dp_stat_t stat,
	output dsrs_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StEval   = 3'd1;
	localparam logic [2:0] StMul    = 3'd2;
	localparam logic [2:0] StDiv    = 3'd3;
	localparam logic [2:0] StFinish = 3'd4;

	logic [2:0] state_q, state_d;
	logic [1:0] status_q, status_d;
	logic       done_q, done_d;
	logic       start_q, start_d;

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		done_d   = done_q;
		start_d  = start_q;
		cmd      = '0;
		cmd.status = status_q;
		cmd.done   = done_q;
		s_tready = (state_q == StIdle);
		case (state_q)
			StIdle: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d   = StEval;
				end
			end
			StEval: begin
				done_d  = 1'b0;
				start_d = stat.is_start;
				if (stat.is_start) begin
					if (stat.running) begin
						status_d = dsrs_pkg::StatRejected;
						state_d  = StFinish;
					end else begin
						cmd.setup   = 1'b1;
						cmd.div_min = 1'b1;
						status_d    = dsrs_pkg::StatAccepted;
						state_d     = StDiv;
					end
				end else if (!stat.running) begin
					status_d = dsrs_pkg::StatIdle;
					state_d  = StFinish;
				end else if (stat.interval_gt1) begin
					cmd.decrement = 1'b1;
					status_d      = dsrs_pkg::StatRunning;
					state_d       = StFinish;
				end else if (stat.steps_left) begin
					cmd.mul  = 1'b1;
					status_d = dsrs_pkg::StatRunning;
					state_d  = StMul;
				end else begin
					cmd.stop = 1'b1;
					done_d   = 1'b1;
					status_d = dsrs_pkg::StatIdle;
					state_d  = StFinish;
				end
			end
			StMul: begin
				cmd.div_ramp = 1'b1;
				state_d      = StDiv;
			end
			StDiv: begin
				if (stat.div_done) begin
					cmd.set_interval = 1'b1;
					cmd.step         = !start_q;
					state_d          = StFinish;
				end
			end
			StFinish: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			status_q <= dsrs_pkg::StatIdle;
			done_q   <= 1'b0;
			start_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			done_q   <= done_d;
			start_q  <= start_d;
		end
	end

endmodule

@@ rtl/dual_stepper_ramp_sequencer.sv @@
// Top level of the dual stepper ramp sequencer: controller plus datapath.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tdata: move request, tuser: action
//  m_*       out  m_tvalid/m_tready   tdata: coil drives, status, move_done
//  cfg_*     in   cfg_we              cfg_index selects register, cfg_data value
//
// A start, and an interval expiry with steps left, wait for the serial divider that
// turns the step rate into a tick interval.
// Reset clears all motor state, coils off, and loads register defaults.
// A result waiting in the output register does not stop the next item from
// being taken; only the finishing cycle waits for that register to free up.
module dual_stepper_ramp_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [11:0] zoom_steps, [12] zoom_toward_tele, [24:13] focus_steps,
	// [25] focus_toward_far, [31:26] zero
	input  logic [31:0] s_tdata,
	// [0] action
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [3:0] zoom_coils, [7:4] focus_coils, [9:8] status, [10] move_done, [15:11] zero
	output logic [15:0] m_tdata
);

	dsrs_pkg::dp_cmd_t  cmd;
	dsrs_pkg::dp_stat_t stat;

	dsrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsrs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule

@@ dv/tb_top.sv @@
// Testbench for the dual stepper ramp sequencer: predicts or plans every result and checks it.
`timescale 1ns / 1ps

module tb_top;

	localparam logic ActTick      = ~dsrs_pkg::ActStart;
	localparam int   RandItems    = 850;
	localparam int   SettleCycles = 40;
	localparam int   MaxReports   = 200;

	typedef struct packed {
		logic        action;
		logic [11:0] zoom_steps;
		logic        zoom_tele;
		logic [11:0] focus_steps;
		logic        focus_far;
	} move_item_t;

	typedef struct packed {
		logic [3:0] zoom_coils;
		logic [3:0] focus_coils;
		logic [1:0] status;
		logic       move_done;
	} coil_result_t;

	typedef struct {
		logic         is_cfg;
		move_item_t   item;
		int           reps;
		logic         typed;
		coil_result_t want;
		logic         half;
		logic [15:0]  rmin;
		logic [15:0]  rmax;
		logic [15:0]  rinc;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = dsrs_pkg::RegEightPhase;
	logic [15:0] cfg_data = 16'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	dual_stepper_ramp_sequencer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// predictor state
	logic        half_step = 1'b0;
	logic [15:0] rate_min = 16'd300;
	logic [15:0] rate_max = 16'd800;
	logic [15:0] rate_inc = 16'd15;
	logic [11:0] z_left = '0, f_left = '0;
	logic        z_dir = 1'b0, f_dir = 1'b0;
	logic [2:0]  z_ph = '0, f_ph = '0;
	logic [1:0]  ramp_sel = dsrs_pkg::RampNone;
	logic [11:0] ramp_len = '0;
	logic [19:0] ticks_left = '0;
	logic        motor_busy = 1'b0;
	logic [3:0]  z_drv = '0, f_drv = '0;

	coil_result_t drive_expect_q[$];
	plan_row_t    plan_q[$];
	int           mismatches = 0;
	int           stall_left = 0;
	bit           allow_idle = 1'b1;

	function automatic logic [19:0] tick_period(input longint unsigned spd);
		longint unsigned q;
		if (spd == 0)
			spd = 1;
		q = longint'(dsrs_pkg::TicksPerSecond) / spd;
		return q[19:0];
	endfunction

	function automatic logic [19:0] next_interval();
		longint unsigned cur, prog, spd;
		if (ramp_sel != dsrs_pkg::RampZoom && ramp_sel != dsrs_pkg::RampFocus)
			return tick_period(rate_min);
		cur = (ramp_sel == dsrs_pkg::RampZoom) ? z_left : f_left;
		if (cur <= (ramp_len >> 1))
			prog = cur;
		else if (cur > ramp_len)
			prog = 0;
		else
			prog = ramp_len - cur;
		spd = rate_min + prog * rate_inc;
		if (spd >= rate_max)
			spd = rate_max;
		return tick_period(spd);
	endfunction

	function automatic logic [2:0] step_phase(input logic [2:0] ph, input logic dir);
		logic [2:0] mask;
		mask = half_step ? 3'd7 : 3'd3;
		return dir ? ((ph + mask) & mask) : ((ph + 3'd1) & mask);
	endfunction

	function automatic logic [3:0] coil_pattern(input logic [2:0] p);
		if (half_step) begin
			case (p)
				3'd0: return 4'h1;
				3'd1: return 4'h5;
				3'd2: return 4'h4;
				3'd3: return 4'h6;
				3'd4: return 4'h2;
				3'd5: return 4'hA;
				3'd6: return 4'h8;
				default: return 4'h9;
			endcase
		end
		case (p[1:0])
			2'd0: return 4'h9;
			2'd1: return 4'h5;
			2'd2: return 4'h6;
			default: return 4'hA;
		endcase
	endfunction

	task automatic advance_motors(input move_item_t it, output coil_result_t res);
		logic [1:0] stat;
		logic       fin;
		logic [3:0] e;
		stat = dsrs_pkg::StatIdle;
		fin = 1'b0;
		if (it.action == dsrs_pkg::ActStart) begin
			if (motor_busy) begin
				stat = dsrs_pkg::StatRejected;
			end else begin
				z_left = it.zoom_steps;
				f_left = it.focus_steps;
				z_dir = it.zoom_tele;
				f_dir = it.focus_far;
				if (z_left != 0 && f_left == 0) begin
					ramp_sel = dsrs_pkg::RampZoom;
					ramp_len = z_left;
				end else if (z_left == 0 && f_left != 0) begin
					ramp_sel = dsrs_pkg::RampFocus;
					ramp_len = f_left;
				end else if (z_left != 0 && f_left != 0) begin
					ramp_sel = (z_left > f_left) ? dsrs_pkg::RampFocus : dsrs_pkg::RampZoom;
					ramp_len = (z_left > f_left) ? f_left : z_left;
				end else begin
					ramp_sel = dsrs_pkg::RampNone;
					ramp_len = '0;
				end
				ticks_left = tick_period(rate_min);
				motor_busy = 1'b1;
				stat = dsrs_pkg::StatAccepted;
			end
		end else if (motor_busy) begin
			if (ticks_left > 1) begin
				ticks_left--;
				stat = dsrs_pkg::StatRunning;
			end else if (z_left != 0 || f_left != 0) begin
				ticks_left = next_interval();
				if (z_left != 0) begin
					z_ph = step_phase(z_ph, z_dir);
					e = coil_pattern(z_ph);
					z_drv = {e[3], e[0], e[1], e[2]};
					z_left--;
				end
				if (f_left != 0) begin
					f_ph = step_phase(f_ph, f_dir);
					f_drv = coil_pattern(f_ph);
					f_left--;
				end
				stat = dsrs_pkg::StatRunning;
			end else begin
				z_drv = '0;
				f_drv = '0;
				motor_busy = 1'b0;
				fin = 1'b1;
			end
		end
		res = '{z_drv, f_drv, stat, fin};
	endtask

	task automatic check_result(input coil_result_t got);
		coil_result_t want;
		if (drive_expect_q.size() == 0) begin
			if (mismatches < MaxReports)
				$display("%0t: unexpected item, expected none, actual %h", $time, got);
			mismatches++;
			return;
		end
		want = drive_expect_q.pop_front();
		if (got != want) begin
			if (mismatches < MaxReports)
				$display("%0t: zoom/focus/status/done expected %h/%h/%0d/%0d actual %h/%h/%0d/%0d",
					$time, want.zoom_coils, want.focus_coils, want.status, want.move_done,
					got.zoom_coils, got.focus_coils, got.status, got.move_done);
			mismatches++;
		end
	endtask

	// output side: checker plus random backpressure
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result('{m_tdata[3:0], m_tdata[7:4], m_tdata[9:8], m_tdata[10]});
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (allow_idle && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(input move_item_t it, input logic typed, input coil_result_t want);
		coil_result_t res;
		if (allow_idle && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, it.focus_far, it.focus_steps, it.zoom_tele, it.zoom_steps};
		s_tuser  <= it.action;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		advance_motors(it, res);
		drive_expect_q.push_back(typed ? want : res);
	endtask

	task automatic apply_settings(input logic half, input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] inc);
		s_tvalid <= 1'b0;
		while (drive_expect_q.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= dsrs_pkg::RegEightPhase;
		cfg_data  <= {15'd0, half};
		@(posedge clk);
		cfg_index <= dsrs_pkg::RegSpeedMin;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= dsrs_pkg::RegSpeedMax;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= dsrs_pkg::RegSpeedInc;
		cfg_data  <= inc;
		@(posedge clk);
		cfg_we <= 1'b0;
		half_step = half;
		rate_min = lo;
		rate_max = hi;
		rate_inc = inc;
	endtask

	task automatic tick_until_stopped();
		while (motor_busy)
			send_item('{ActTick, 12'd0, 1'b0, 12'd0, 1'b0}, 1'b0, '0);
	endtask

	function automatic void plan_item(input logic act, input logic [11:0] z, input logic tele,
			input logic [11:0] f, input logic far, input int reps, input logic typed,
			input logic [1:0] stat);
		plan_row_t r;
		r = '{default: '0};
		r.item = '{act, z, tele, f, far};
		r.reps = reps;
		r.typed = typed;
		r.want = '{4'h0, 4'h0, stat, 1'b0};
		plan_q.push_back(r);
	endfunction

	function automatic void plan_cfg(input logic half, input logic [15:0] lo,
			input logic [15:0] hi, input logic [15:0] inc);
		plan_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.half = half;
		r.rmin = lo;
		r.rmax = hi;
		r.rinc = inc;
		plan_q.push_back(r);
	endfunction

	task automatic walk_plan();
		foreach (plan_q[i]) begin
			if (plan_q[i].is_cfg)
				apply_settings(plan_q[i].half, plan_q[i].rmin, plan_q[i].rmax, plan_q[i].rinc);
			else
				repeat (plan_q[i].reps) send_item(plan_q[i].item, plan_q[i].typed, plan_q[i].want);
		end
		plan_q.delete();
	endtask

	function automatic logic [11:0] pick_steps();
		case ($urandom_range(0, 9))
			0, 1, 2: return 12'd0;
			9: return 12'($urandom_range(7, 24));
			default: return 12'($urandom_range(1, 6));
		endcase
	endfunction

	initial begin
		move_item_t  it;
		int          counted;
		int          since_cfg;
		int          phase_len;
		logic [15:0] lo, hi, inc;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle tick, extremes, rejection, zero-step move, first steps
		plan_item(ActTick, 12'd0, 1'b0, 12'd0, 1'b0, 1, 1'b1, dsrs_pkg::StatIdle);
		plan_cfg(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		plan_item(dsrs_pkg::ActStart, 12'd0, 1'b0, 12'd0, 1'b0, 1, 1'b1,
			dsrs_pkg::StatAccepted);
		plan_item(dsrs_pkg::ActStart, 12'hFFF, 1'b1, 12'hFFF, 1'b1, 1, 1'b1,
			dsrs_pkg::StatRejected);
		plan_item(ActTick, 12'hFFF, 1'b1, 12'hFFF, 1'b1, 15, 1'b0, dsrs_pkg::StatIdle);
		plan_item(ActTick, 12'd0, 1'b0, 12'd0, 1'b0, 1, 1'b1, dsrs_pkg::StatIdle);
		plan_item(dsrs_pkg::ActStart, 12'd1, 1'b0, 12'd2, 1'b1, 1, 1'b1,
			dsrs_pkg::StatAccepted);
		plan_item(ActTick, 12'd0, 1'b0, 12'd0, 1'b0, 16, 1'b0, dsrs_pkg::StatIdle);
		walk_plan();

		// a longer move on both motors
		tick_until_stopped();
		send_item('{dsrs_pkg::ActStart, 12'd16, 1'b1, 12'd5, 1'b0}, 1'b0, '0);
		tick_until_stopped();

		counted = 0;
		since_cfg = 0;
		phase_len = $urandom_range(150, 350);
		while (counted < RandItems) begin
			if (since_cfg >= phase_len) begin
				lo = 16'($urandom_range(30000, 65535));
				hi = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(lo, 65535));
				case ($urandom_range(0, 3))
					0: inc = 16'd0;
					1: inc = 16'($urandom_range(1, 400));
					2: inc = 16'($urandom_range(400, 4000));
					default: inc = 16'($urandom_range(0, 65535));
				endcase
				apply_settings(1'($urandom_range(0, 1)), lo, hi, inc);
				since_cfg = 0;
				phase_len = $urandom_range(150, 350);
			end
			if (counted > RandItems * 85 / 100)
				allow_idle = 1'b0;
			if (motor_busy) begin
				it = '{ActTick, 12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
					12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1))};
				if ($urandom_range(0, 39) == 0)
					it.action = dsrs_pkg::ActStart;
				else
					counted++;
			end else if ($urandom_range(0, 19) == 0) begin
				it = '{ActTick, 12'd0, 1'b0, 12'd0, 1'b0};
			end else begin
				it = '{dsrs_pkg::ActStart, pick_steps(), 1'($urandom_range(0, 1)), pick_steps(),
					1'($urandom_range(0, 1))};
				counted++;
			end
			since_cfg++;
			send_item(it, 1'b0, '0);
		end
		tick_until_stopped();

		// slowest rates: a start loads the longest interval
		plan_cfg(1'b0, 16'd1, 16'd1, 16'd0);
		plan_item(dsrs_pkg::ActStart, 12'd3, 1'b1, 12'd5, 1'b0, 1, 1'b1,
			dsrs_pkg::StatAccepted);
		plan_item(ActTick, 12'd0, 1'b0, 12'd0, 1'b0, 3, 1'b0, dsrs_pkg::StatIdle);
		walk_plan();

		s_tvalid <= 1'b0;
		while (drive_expect_q.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0)
			$display("[dual_stepper_ramp_sequencer] OK");
		else
			$display("[dual_stepper_ramp_sequencer] ERROR");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("[dual_stepper_ramp_sequencer] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/dsrs_pkg.sv
rtl/dsrs_div.sv
rtl/dsrs_dp.sv
rtl/dsrs_ctrl.sv
rtl/dual_stepper_ramp_sequencer.sv
dv/tb_top.sv
